>>> hw/rtl/lrr_pkg.sv
// lrr_pkg: types, codes and constants of the layout rectangle resolver
// no dependencies; used by every module of the block

package lrr_pkg;

  // field widths
  localparam int unsigned DispW   = 14;  // display size registers
  localparam int unsigned CoordW  = 16;  // input coordinates and amounts
  localparam int unsigned UnitW   = 3;
  localparam int unsigned AnchW   = 3;
  localparam int unsigned OutW    = 32;
  localparam int unsigned CfgIdxW = 2;

  // internal widths
  localparam int unsigned PadNumW = DispW - 2;       // display size / 4
  localparam int unsigned PadW    = 10;              // 5 percent margin, at most 819
  localparam int unsigned ParW    = CoordW + 1;      // parent values, given or work area
  localparam int unsigned ProdW   = 2 * CoordW + 1;  // size operand times amount
  localparam int unsigned MagW    = 2 * CoordW - 1;  // magnitude of that product
  localparam int unsigned NumW    = MagW - 2;        // magnitude / 4
  localparam int unsigned RecW    = 28;
  localparam int unsigned QW      = 25;              // quotient by 25
  localparam int unsigned SizeW   = 25;              // resolved size
  localparam int unsigned DiffW   = SizeW + 1;       // parent size minus size
  localparam int unsigned PosW    = DiffW + 1;       // position

  // divide by 5: (n * 52429) >> 18, exact for n below 4096
  localparam int unsigned Rec5W   = 17;
  localparam int unsigned Rec5Sh  = 18;
  localparam logic [Rec5W-1:0] Recip5 = 17'd52429;

  // divide by 25: (n * floor(2^32 / 25)) >> 32, low by at most one
  localparam int unsigned Rec25Sh = 32;
  localparam logic [RecW-1:0] Recip25 = 28'd171798691;
  localparam int unsigned Div25   = 25;

  // register reset values
  localparam logic [DispW-1:0] DispWidthRst  = 14'd1920;
  localparam logic [DispW-1:0] DispHeightRst = 14'd1080;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDispWidth  = 2'd0,
    CfgDispHeight = 2'd1
  } cfg_idx_e;

  typedef enum logic [UnitW-1:0] {
    UnitPx   = 3'd0,
    UnitPct  = 3'd1,
    UnitVw   = 3'd2,
    UnitVh   = 3'd3,
    UnitFill = 3'd4,
    UnitAuto = 3'd5
  } unit_e;

  typedef enum logic [AnchW-1:0] {
    AnchNone    = 3'd0,
    AnchCenter  = 3'd1,
    AnchTop     = 3'd2,
    AnchBottom  = 3'd3,
    AnchLeft    = 3'd4,
    AnchRight   = 3'd5,
    AnchStretch = 3'd6,
    AnchFill    = 3'd7
  } anchor_e;

  typedef struct packed {
    logic                     cmd;
    logic signed [CoordW-1:0] parent_x;
    logic signed [CoordW-1:0] parent_y;
    logic signed [CoordW-1:0] parent_width;
    logic signed [CoordW-1:0] parent_height;
    logic [UnitW-1:0]         width_unit;
    logic signed [CoordW-1:0] width_amount;
    logic [UnitW-1:0]         height_unit;
    logic signed [CoordW-1:0] height_amount;
    logic [AnchW-1:0]         anchor;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] rect_x;
    logic signed [OutW-1:0] rect_y;
    logic signed [OutW-1:0] rect_width;
    logic signed [OutW-1:0] rect_height;
  } out_t;

  // load enables of the middle pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

>>> hw/rtl/lrr_size_axis.sv
// lrr_size_axis: resolves one size spec (width or height) over three stages
// depends on lrr_pkg

module lrr_size_axis (
  input  logic                              clk_i,
  input  lrr_pkg::stage_en_t                en_i,
  input  logic [lrr_pkg::UnitW-1:0]         unit_i,
  input  logic signed [lrr_pkg::CoordW-1:0] amount_i,
  input  logic signed [lrr_pkg::ParW-1:0]   psize_i,
  input  logic [lrr_pkg::DispW-1:0]         disp_w_i,
  input  logic [lrr_pkg::DispW-1:0]         disp_h_i,
  output logic signed [lrr_pkg::SizeW-1:0]  size_o
);

  // stage 2: operand select and multiply
  logic signed [lrr_pkg::ParW-1:0]   op_a;
  logic signed [lrr_pkg::ProdW-1:0]  prod_d, prod_q;
  logic [lrr_pkg::UnitW-1:0]         unit2_q;
  logic signed [lrr_pkg::CoordW-1:0] amount2_q;
  logic signed [lrr_pkg::ParW-1:0]   psize2_q;

  always_comb begin
    case (unit_i)
      lrr_pkg::UnitVw: op_a = lrr_pkg::ParW'($signed({1'b0, disp_w_i}));
      lrr_pkg::UnitVh: op_a = lrr_pkg::ParW'($signed({1'b0, disp_h_i}));
      default:         op_a = psize_i;
    endcase
    prod_d = lrr_pkg::ProdW'(op_a) * lrr_pkg::ProdW'(amount_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q    <= prod_d;
      unit2_q   <= unit_i;
      amount2_q <= amount_i;
      psize2_q  <= psize_i;
    end
  end

  // stage 3: magnitude, drop the factor 4, reciprocal multiply by 1/25
  logic [lrr_pkg::ProdW-1:0]         mag;
  logic [lrr_pkg::NumW-1:0]          num_d, num_q;
  logic [lrr_pkg::NumW+lrr_pkg::RecW-1:0] rec;
  logic [lrr_pkg::QW-1:0]            q0_q;
  logic                              neg_q;
  logic [lrr_pkg::UnitW-1:0]         unit3_q;
  logic signed [lrr_pkg::CoordW-1:0] amount3_q;
  logic signed [lrr_pkg::ParW-1:0]   psize3_q;

  always_comb begin
    mag   = prod_q[lrr_pkg::ProdW-1] ? lrr_pkg::ProdW'(-prod_q) : lrr_pkg::ProdW'(prod_q);
    num_d = mag[lrr_pkg::MagW-1:2];
    rec   = (lrr_pkg::NumW + lrr_pkg::RecW)'(num_d)
          * (lrr_pkg::NumW + lrr_pkg::RecW)'(lrr_pkg::Recip25);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      num_q     <= num_d;
      q0_q      <= rec[lrr_pkg::Rec25Sh +: lrr_pkg::QW];
      neg_q     <= prod_q[lrr_pkg::ProdW-1];
      unit3_q   <= unit2_q;
      amount3_q <= amount2_q;
      psize3_q  <= psize2_q;
    end
  end

  // stage 4: one correction step, sign, unit select
  logic [lrr_pkg::NumW-1:0]         q0x25, rem;
  logic [lrr_pkg::QW-1:0]           quo;
  logic signed [lrr_pkg::SizeW-1:0] squo;
  logic signed [lrr_pkg::SizeW-1:0] size_d, size_q;

  always_comb begin
    q0x25 = (lrr_pkg::NumW'(q0_q) << 4) + (lrr_pkg::NumW'(q0_q) << 3) + lrr_pkg::NumW'(q0_q);
    rem   = num_q - q0x25;
    quo   = (rem >= lrr_pkg::NumW'(lrr_pkg::Div25)) ? q0_q + lrr_pkg::QW'(1) : q0_q;
    squo  = neg_q ? -$signed(quo) : $signed(quo);
    case (unit3_q)
      lrr_pkg::UnitPx,
      lrr_pkg::UnitAuto: size_d = lrr_pkg::SizeW'(amount3_q);
      lrr_pkg::UnitPct,
      lrr_pkg::UnitVw,
      lrr_pkg::UnitVh:   size_d = squo;
      lrr_pkg::UnitFill: size_d = lrr_pkg::SizeW'(psize3_q);
      default:           size_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      size_q <= size_d;
    end
  end

  assign size_o = size_q;

endmodule

>>> hw/rtl/lrr_anchor_place.sv
// lrr_anchor_place: places and stretches the box inside the parent by anchor
// depends on lrr_pkg

module lrr_anchor_place (
  input  logic [lrr_pkg::AnchW-1:0]       anchor_i,
  input  logic signed [lrr_pkg::ParW-1:0] px_i,
  input  logic signed [lrr_pkg::ParW-1:0] py_i,
  input  logic signed [lrr_pkg::ParW-1:0] pw_i,
  input  logic signed [lrr_pkg::ParW-1:0] ph_i,
  input  logic signed [lrr_pkg::SizeW-1:0] w_i,
  input  logic signed [lrr_pkg::SizeW-1:0] h_i,
  output lrr_pkg::out_t                   rect_o
);

  logic signed [lrr_pkg::DiffW-1:0] dx, dy, adj_x, adj_y, half_x, half_y;
  logic signed [lrr_pkg::PosW-1:0]  x_org, y_org, x_mid, y_mid, x_end, y_end, x, y;

  always_comb begin
    dx = lrr_pkg::DiffW'(pw_i) - lrr_pkg::DiffW'(w_i);
    dy = lrr_pkg::DiffW'(ph_i) - lrr_pkg::DiffW'(h_i);
    // halving that truncates toward zero
    adj_x  = dx + $signed({{(lrr_pkg::DiffW-1){1'b0}}, dx[lrr_pkg::DiffW-1]});
    adj_y  = dy + $signed({{(lrr_pkg::DiffW-1){1'b0}}, dy[lrr_pkg::DiffW-1]});
    half_x = adj_x >>> 1;
    half_y = adj_y >>> 1;

    x_org = lrr_pkg::PosW'(px_i);
    y_org = lrr_pkg::PosW'(py_i);
    x_mid = x_org + lrr_pkg::PosW'(half_x);
    y_mid = y_org + lrr_pkg::PosW'(half_y);
    x_end = x_org + lrr_pkg::PosW'(dx);
    y_end = y_org + lrr_pkg::PosW'(dy);

    rect_o.rect_width  = lrr_pkg::OutW'(w_i);
    rect_o.rect_height = lrr_pkg::OutW'(h_i);
    case (anchor_i)
      lrr_pkg::AnchCenter: begin
        x = x_mid;
        y = y_mid;
      end
      lrr_pkg::AnchTop: begin
        x = x_mid;
        y = y_org;
      end
      lrr_pkg::AnchBottom: begin
        x = x_mid;
        y = y_end;
      end
      lrr_pkg::AnchLeft: begin
        x = x_org;
        y = y_mid;
      end
      lrr_pkg::AnchRight: begin
        x = x_end;
        y = y_mid;
      end
      lrr_pkg::AnchStretch: begin
        x = x_org;
        y = y_mid;
        rect_o.rect_width = lrr_pkg::OutW'(pw_i);
      end
      lrr_pkg::AnchFill: begin
        x = x_org;
        y = y_org;
        rect_o.rect_width  = lrr_pkg::OutW'(pw_i);
        rect_o.rect_height = lrr_pkg::OutW'(ph_i);
      end
      default: begin
        x = x_org;
        y = y_org;
      end
    endcase
    rect_o.rect_x = lrr_pkg::OutW'(x);
    rect_o.rect_y = lrr_pkg::OutW'(y);
  end

endmodule

>>> hw/rtl/ui_layout_rect_resolver.sv
// ui_layout_rect_resolver: top level, five stage layout rectangle pipeline
// depends on lrr_pkg, lrr_size_axis, lrr_anchor_place
//
//   channel | signals                                   | dir | transfer when
//   --------+-------------------------------------------+-----+-------------------------
//   in      | in_valid_i, in_stall_o, in_data_i         | in  | in_valid_i & !in_stall_o
//   out     | out_valid_o, out_stall_i, out_data_o      | out | out_valid_o & !out_stall_i
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in  | cfg_valid_i & cfg_ready_o
//           | cfg_data_i                                |     |
//
// one item per cycle sustained while the output is not stalled
// stages: margin divide, parent select + size multiply, 1/25 reciprocal multiply,
// correction + unit select, anchor placement into the output register
// each stage loads when it is empty or the stage after it moves, so stalls only
// hold items in place and bubbles are squeezed out
// reset clears the stage valid bits and restores the display size registers

module ui_layout_rect_resolver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lrr_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lrr_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lrr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lrr_pkg::DispW-1:0]          cfg_data_i
);

  // display size registers, always ready for a transfer
  logic [lrr_pkg::DispW-1:0] disp_w_q, disp_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q <= lrr_pkg::DispWidthRst;
      disp_h_q <= lrr_pkg::DispHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lrr_pkg::CfgDispWidth:  disp_w_q <= cfg_data_i;
        lrr_pkg::CfgDispHeight: disp_h_q <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // stage enables, computed back from the output
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic en1, en2, en3, en4, en5;
  lrr_pkg::stage_en_t stage_en;

  assign en5 = !out_v_q || !out_stall_i;
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_stall_o = !en1;

  assign stage_en.s2 = en2;
  assign stage_en.s3 = en3;
  assign stage_en.s4 = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q  <= in_valid_i;
      if (en2) s2_v_q  <= s1_v_q;
      if (en3) s3_v_q  <= s2_v_q;
      if (en4) s4_v_q  <= s3_v_q;
      if (en5) out_v_q <= s4_v_q;
    end
  end

  // stage 1: work area margin, size * 5 / 100 = (size / 4) / 5
  logic [lrr_pkg::PadNumW+lrr_pkg::Rec5W-1:0] pad_x_prod, pad_y_prod;
  lrr_pkg::in_t              s1_item_q;
  logic [lrr_pkg::PadW-1:0]  s1_pad_x_q, s1_pad_y_q;

  assign pad_x_prod = (lrr_pkg::PadNumW + lrr_pkg::Rec5W)'(disp_w_q[lrr_pkg::DispW-1:2])
                    * (lrr_pkg::PadNumW + lrr_pkg::Rec5W)'(lrr_pkg::Recip5);
  assign pad_y_prod = (lrr_pkg::PadNumW + lrr_pkg::Rec5W)'(disp_h_q[lrr_pkg::DispW-1:2])
                    * (lrr_pkg::PadNumW + lrr_pkg::Rec5W)'(lrr_pkg::Recip5);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_item_q  <= in_data_i;
      s1_pad_x_q <= pad_x_prod[lrr_pkg::Rec5Sh +: lrr_pkg::PadW];
      s1_pad_y_q <= pad_y_prod[lrr_pkg::Rec5Sh +: lrr_pkg::PadW];
    end
  end

  // stage 2: parent rectangle, given or work area
  logic signed [lrr_pkg::ParW-1:0] par_x, par_y, par_w, par_h;

  always_comb begin
    if (s1_item_q.cmd) begin
      par_x = lrr_pkg::ParW'($signed({1'b0, s1_pad_x_q}));
      par_y = lrr_pkg::ParW'($signed({1'b0, s1_pad_y_q}));
      par_w = lrr_pkg::ParW'($signed({1'b0, disp_w_q}))
            - lrr_pkg::ParW'($signed({1'b0, s1_pad_x_q, 1'b0}));
      par_h = lrr_pkg::ParW'($signed({1'b0, disp_h_q}))
            - lrr_pkg::ParW'($signed({1'b0, s1_pad_y_q, 1'b0}));
    end else begin
      par_x = lrr_pkg::ParW'(s1_item_q.parent_x);
      par_y = lrr_pkg::ParW'(s1_item_q.parent_y);
      par_w = lrr_pkg::ParW'(s1_item_q.parent_width);
      par_h = lrr_pkg::ParW'(s1_item_q.parent_height);
    end
  end

  // parent rectangle and anchor ride along stages 2 to 4
  logic signed [lrr_pkg::ParW-1:0] s2_px_q, s2_py_q, s2_pw_q, s2_ph_q;
  logic signed [lrr_pkg::ParW-1:0] s3_px_q, s3_py_q, s3_pw_q, s3_ph_q;
  logic signed [lrr_pkg::ParW-1:0] s4_px_q, s4_py_q, s4_pw_q, s4_ph_q;
  logic [lrr_pkg::AnchW-1:0]       s2_anch_q, s3_anch_q, s4_anch_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_px_q   <= par_x;
      s2_py_q   <= par_y;
      s2_pw_q   <= par_w;
      s2_ph_q   <= par_h;
      s2_anch_q <= s1_item_q.anchor;
    end
    if (en3) begin
      s3_px_q   <= s2_px_q;
      s3_py_q   <= s2_py_q;
      s3_pw_q   <= s2_pw_q;
      s3_ph_q   <= s2_ph_q;
      s3_anch_q <= s2_anch_q;
    end
    if (en4) begin
      s4_px_q   <= s3_px_q;
      s4_py_q   <= s3_py_q;
      s4_pw_q   <= s3_pw_q;
      s4_ph_q   <= s3_ph_q;
      s4_anch_q <= s3_anch_q;
    end
  end

  // stages 2 to 4: width and height specs, one unit per axis
  logic signed [lrr_pkg::SizeW-1:0] s4_w, s4_h;

  lrr_size_axis u_width (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .unit_i   (s1_item_q.width_unit),
    .amount_i (s1_item_q.width_amount),
    .psize_i  (par_w),
    .disp_w_i (disp_w_q),
    .disp_h_i (disp_h_q),
    .size_o   (s4_w)
  );

  lrr_size_axis u_height (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .unit_i   (s1_item_q.height_unit),
    .amount_i (s1_item_q.height_amount),
    .psize_i  (par_h),
    .disp_w_i (disp_w_q),
    .disp_h_i (disp_h_q),
    .size_o   (s4_h)
  );

  // stage 5: anchor placement into the output register
  lrr_pkg::out_t rect_d, out_data_q;

  lrr_anchor_place u_place (
    .anchor_i (s4_anch_q),
    .px_i     (s4_px_q),
    .py_i     (s4_py_q),
    .pw_i     (s4_pw_q),
    .ph_i     (s4_ph_q),
    .w_i      (s4_w),
    .h_i      (s4_h),
    .rect_o   (rect_d)
  );

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_data_q <= rect_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // the input only stalls when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s2_v_q && s3_v_q && s4_v_q && out_v_q))
    else $error("input stalled with a free pipeline stage");

  // a free output never backs up into the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // an item held in the last middle stage is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_v_q && !en5) |=> s4_v_q)
    else $error("stage 4 item lost during output stall");

  // an item held in the first stage is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !en2) |=> (s1_v_q && $stable(s1_item_q)))
    else $error("stage 1 item changed during stall");
`endif

endmodule

>>> bench/tb.sv
// tb: self-checking bench for ui_layout_rect_resolver
// depends on lrr_pkg and the rtl of the resolver; predicts every rectangle itself

module tb;
  import lrr_pkg::*;

  localparam int          ClkHalf      = 5;
  localparam int          ResetCycles  = 9;
  localparam int          CycleLimit   = 1000000;
  localparam int          SettleCycles = 10;   // pipeline is 5 deep, leave some slack
  localparam int          HoldCycles   = 200;  // long output hold-off for the fill test
  localparam int          PrintLimit   = 50;
  localparam longint      PctDiv       = 100;
  localparam longint      MarginPct    = 5;
  // index with no register behind it, written once to see it is harmless
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd2;

  logic                 clk = 1'b0;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [DispW-1:0]     cfg_data;

  // bench copy of the display size registers
  logic [DispW-1:0]     disp_w = DispWidthRst;
  logic [DispW-1:0]     disp_h = DispHeightRst;

  out_t                 expected_rects[$];
  int unsigned          err_cnt     = 0;
  int unsigned          cycle_cnt   = 0;
  int unsigned          hold_cycles = 0;
  bit                   idle_en;

  ui_layout_rect_resolver i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(ClkHalf) clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one axis of the box size; unknown unit codes collapse to zero
  function automatic longint axis_size(logic [UnitW-1:0] unit, longint amount,
                                       longint par_size);
    case (unit_e'(unit))
      UnitPx, UnitAuto: return amount;
      UnitPct:          return (par_size * amount) / PctDiv;
      UnitVw:           return (longint'(disp_w) * amount) / PctDiv;
      UnitVh:           return (longint'(disp_h) * amount) / PctDiv;
      UnitFill:         return par_size;
      default:          return 0;
    endcase
  endfunction

  // full rectangle for one request; longint division truncates toward zero
  function automatic out_t resolve_rect(in_t req);
    longint px, py, pw, ph, w, h, x, y, pad_x, pad_y;
    out_t   rect;
    if (req.cmd) begin
      // work area: display minus a 5 percent margin on every side
      pad_x = (longint'(disp_w) * MarginPct) / PctDiv;
      pad_y = (longint'(disp_h) * MarginPct) / PctDiv;
      px = pad_x;
      py = pad_y;
      pw = longint'(disp_w) - 2 * pad_x;
      ph = longint'(disp_h) - 2 * pad_y;
    end else begin
      px = longint'($signed(req.parent_x));
      py = longint'($signed(req.parent_y));
      pw = longint'($signed(req.parent_width));
      ph = longint'($signed(req.parent_height));
    end
    w = axis_size(req.width_unit, longint'($signed(req.width_amount)), pw);
    h = axis_size(req.height_unit, longint'($signed(req.height_amount)), ph);
    case (anchor_e'(req.anchor))
      AnchCenter: begin
        x = px + (pw - w) / 2;
        y = py + (ph - h) / 2;
      end
      AnchTop: begin
        x = px + (pw - w) / 2;
        y = py;
      end
      AnchBottom: begin
        x = px + (pw - w) / 2;
        y = py + ph - h;
      end
      AnchLeft: begin
        x = px;
        y = py + (ph - h) / 2;
      end
      AnchRight: begin
        x = px + pw - w;
        y = py + (ph - h) / 2;
      end
      AnchStretch: begin
        // full parent width, centered vertically on the resolved height
        x = px;
        w = pw;
        y = py + (ph - h) / 2;
      end
      AnchFill: begin
        x = px;
        y = py;
        w = pw;
        h = ph;
      end
      default: begin
        x = px;
        y = py;
      end
    endcase
    rect.rect_x      = x[OutW-1:0];
    rect.rect_y      = y[OutW-1:0];
    rect.rect_width  = w[OutW-1:0];
    rect.rect_height = h[OutW-1:0];
    return rect;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly a few cycles, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int unsigned send_gap();
    if (!idle_en || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  // amounts and coordinates: extremes, small values near zero, or anything
  function automatic logic [CoordW-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      1, 2, 3, 4: v = int'($urandom_range(0, 400)) - 200;
      default:    v = int'($urandom);
    endcase
    return v[CoordW-1:0];
  endfunction

  function automatic in_t make_request(logic cmd, int px, int py, int pw, int ph,
                                       int wu, int wa, int hu, int ha, int anch);
    in_t req;
    req.cmd           = cmd;
    req.parent_x      = px[CoordW-1:0];
    req.parent_y      = py[CoordW-1:0];
    req.parent_width  = pw[CoordW-1:0];
    req.parent_height = ph[CoordW-1:0];
    req.width_unit    = wu[UnitW-1:0];
    req.width_amount  = wa[CoordW-1:0];
    req.height_unit   = hu[UnitW-1:0];
    req.height_amount = ha[CoordW-1:0];
    req.anchor        = anch[AnchW-1:0];
    return req;
  endfunction

  function automatic in_t rand_request();
    in_t req;
    req.cmd           = ($urandom_range(0, 3) == 0);
    req.parent_x      = rand_coord();
    req.parent_y      = rand_coord();
    req.parent_width  = rand_coord();
    req.parent_height = rand_coord();
    req.width_unit    = UnitW'($urandom_range(0, 7));
    req.width_amount  = rand_coord();
    req.height_unit   = UnitW'($urandom_range(0, 7));
    req.height_amount = rand_coord();
    req.anchor        = AnchW'($urandom_range(0, 7));
    return req;
  endfunction

  // offer one request, hold it until the transfer, then record its rectangle
  task automatic send_item(input in_t req);
    int unsigned gap;
    gap = send_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    expected_rects.push_back(resolve_rect(req));
  endtask

  // stop offering and let every outstanding rectangle come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // one register write; the trailing edge keeps valid low for a step
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DispW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgDispWidth:  disp_w = value[DispW-1:0];
      CfgDispHeight: disp_h = value[DispW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    if (err_cnt <= PrintLimit)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, none while idling is off, plus a long hold when the fill test asks
  // ---------------------------------------------------------------------------
  initial begin : stall_gen
    int unsigned run_left;
    bit          stalling;
    out_stall = 1'b0;
    run_left  = 0;
    stalling  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (!idle_en) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 99) < 35);
          run_left = stalling ? idle_len() : $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking: every result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_rects.size() == 0) begin
        report_mismatch("unexpected result x", longint'(out_data.rect_x), 0);
      end else begin
        want = expected_rects.pop_front();
        if (out_data.rect_x !== want.rect_x)
          report_mismatch("rect_x", longint'(out_data.rect_x), longint'(want.rect_x));
        if (out_data.rect_y !== want.rect_y)
          report_mismatch("rect_y", longint'(out_data.rect_y), longint'(want.rect_y));
        if (out_data.rect_width !== want.rect_width)
          report_mismatch("rect_width", longint'(out_data.rect_width),
                          longint'(want.rect_width));
        if (out_data.rect_height !== want.rect_height)
          report_mismatch("rect_height", longint'(out_data.rect_height),
                          longint'(want.rect_height));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every unit on both axes, every anchor, the work area,
  // all at the reset display size
  task automatic test_directed_cases();
    send_item(make_request(0, 0, 0, 0, 0, UnitPx, 0, UnitPx, 0, AnchNone));
    for (int u = 0; u < 8; u++) begin
      // invalid unit codes 6 and 7 show up on both axes here
      send_item(make_request(0, 100, -50, 32767, 32767, u, 32767, 7 - u, -32768, u));
      send_item(make_request(0, -32768, 32767, -32768, 1000, 7 - u, -32768, u, 32767,
                             7 - u));
    end
    // work area parent: parent fields are junk and must be ignored
    send_item(make_request(1, 1, 2, 3, 4, UnitPct, 50, UnitVh, 20, AnchCenter));
    send_item(make_request(1, -1, -1, -1, -1, UnitVw, -32768, UnitFill, 0, AnchBottom));
    send_item(make_request(1, 0, 0, 0, 0, UnitAuto, 32767, UnitPct, -32768, AnchRight));
    send_item(make_request(0, 32767, 32767, 32767, 32767, UnitPct, 32767, UnitPct, 32767,
                           AnchFill));
    // every input bit high at once but the anchor, which is stretch
    send_item(make_request(1, -1, -1, -1, -1, 7, -1, 7, -1, AnchStretch));
  endtask

  // display size phases: zero size, minimum, maximum, lopsided, random, reset value
  task automatic test_display_sizes();
    int unsigned widths[7];
    int unsigned heights[7];
    widths  = '{0, 1, 16383, 16383, 1, 0, 1920};
    heights = '{0, 1, 16383, 1, 16383, 0, 1080};
    widths[5]  = $urandom_range(1, 16383);
    heights[5] = $urandom_range(1, 16383);
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_reg(CfgDispWidth, widths[p]);
      write_reg(CfgDispHeight, heights[p]);
      if (p == 3) write_reg(CfgSpare, $urandom);
      send_item(make_request(1, 0, 0, 0, 0, UnitVw, 100, UnitVh, -100, AnchCenter));
      send_item(make_request(0, 10, 20, 300, 400, UnitVh, 32767, UnitVw, -32768, AnchTop));
      repeat (60) send_item(rand_request());
    end
  endtask

  // hold the output off for a long stretch while requests keep coming,
  // so the pipeline fills and the input side has to stall
  task automatic test_backpressure();
    idle_en     = 1'b0;
    hold_cycles = HoldCycles;
    repeat (40) send_item(rand_request());
    idle_en     = 1'b1;
  endtask

  // bulk random traffic; every fourth block runs with no idling on either side
  task automatic test_random_traffic();
    for (int blk = 0; blk < 11; blk++) begin
      idle_en = (blk % 4 != 3);
      repeat (100) send_item(rand_request());
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_en   = 1'b1;
    repeat (ResetCycles) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_display_sizes();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lrr_pkg.sv
hw/rtl/lrr_size_axis.sv
hw/rtl/lrr_anchor_place.sv
hw/rtl/ui_layout_rect_resolver.sv
bench/tb.sv
